/* design/ssoc_pkg.sv */
// shared types, opcodes and control word layout for the shell sort block
package ssoc_pkg;

  localparam int DATA_W  = 32;
  localparam int COUNT_W = 16;
  localparam int STEP_W  = 4;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     is_last;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  sorted_value;
    logic                      end_of_set;
    logic        [COUNT_W-1:0] op_count;
  } out_word_t;

  // datapath operations, one per microcode step
  localparam logic [3:0] OP_LOAD  = 4'd0;
  localparam logic [3:0] OP_SETUP = 4'd1;
  localparam logic [3:0] OP_PASS  = 4'd2;
  localparam logic [3:0] OP_ILOAD = 4'd3;
  localparam logic [3:0] OP_HOLD  = 4'd4;
  localparam logic [3:0] OP_CMPRD = 4'd5;
  localparam logic [3:0] OP_CMP   = 4'd6;
  localparam logic [3:0] OP_PLACE = 4'd7;
  localparam logic [3:0] OP_HALVE = 4'd8;
  localparam logic [3:0] OP_ERD   = 4'd9;
  localparam logic [3:0] OP_EOUT  = 4'd10;

  // wait conditions
  localparam logic [1:0] WT_NONE = 2'd0;
  localparam logic [1:0] WT_IN   = 2'd1;
  localparam logic [1:0] WT_OUT  = 2'd2;

  // branch conditions
  localparam logic [3:0] BR_ALWAYS   = 4'd0;
  localparam logic [3:0] BR_NOTLAST  = 4'd1;
  localparam logic [3:0] BR_SETUP_G0 = 4'd2;
  localparam logic [3:0] BR_HALF_NZ  = 4'd3;
  localparam logic [3:0] BR_J_LT_GAP = 4'd4;
  localparam logic [3:0] BR_LESS     = 4'd5;
  localparam logic [3:0] BR_MORE_I   = 4'd6;
  localparam logic [3:0] BR_LAST_K   = 4'd7;

  typedef struct packed {
    logic [3:0]        op;
    logic [1:0]        wait_on;
    logic [3:0]        br;
    logic [STEP_W-1:0] tgt_true;
    logic [STEP_W-1:0] tgt_false;
  } ctrl_word_t;

  // sequencer to datapath
  typedef struct packed {
    logic [3:0] op;
    logic       go;
  } ssoc_ctl_t;

  // datapath to sequencer
  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic is_last;
    logic setup_gap0;
    logic half_nz;
    logic j_lt_gap;
    logic less;
    logic more_i;
    logic last_k;
  } ssoc_flags_t;

endpackage

/* design/ssoc_store.sv */
// element store: one write port, one registered read port
module ssoc_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [ssoc_pkg::DATA_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [ssoc_pkg::DATA_W-1:0] rd_data
);
  import ssoc_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/ssoc_sequencer.sv */
// microcode sequencer: step counter, program rom and branch logic
module ssoc_sequencer (
  input  logic                 clk,
  input  logic                 rst,
  input  ssoc_pkg::ssoc_flags_t flags,
  output ssoc_pkg::ssoc_ctl_t   ctl
);
  import ssoc_pkg::*;

  localparam logic [STEP_W-1:0] S_IDLE  = 4'd0;
  localparam logic [STEP_W-1:0] S_SETUP = 4'd1;
  localparam logic [STEP_W-1:0] S_PASS  = 4'd2;
  localparam logic [STEP_W-1:0] S_ILOAD = 4'd3;
  localparam logic [STEP_W-1:0] S_HOLD  = 4'd4;
  localparam logic [STEP_W-1:0] S_CMPRD = 4'd5;
  localparam logic [STEP_W-1:0] S_CMP   = 4'd6;
  localparam logic [STEP_W-1:0] S_PLACE = 4'd7;
  localparam logic [STEP_W-1:0] S_HALVE = 4'd8;
  localparam logic [STEP_W-1:0] S_ERD   = 4'd9;
  localparam logic [STEP_W-1:0] S_EOUT  = 4'd10;

  function automatic ctrl_word_t rom(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    unique case (step)
      S_IDLE:  w = '{OP_LOAD,  WT_IN,   BR_NOTLAST,  S_IDLE,  S_SETUP};
      S_SETUP: w = '{OP_SETUP, WT_NONE, BR_SETUP_G0, S_ERD,   S_PASS};
      S_PASS:  w = '{OP_PASS,  WT_NONE, BR_ALWAYS,   S_ILOAD, S_ILOAD};
      S_ILOAD: w = '{OP_ILOAD, WT_NONE, BR_ALWAYS,   S_HOLD,  S_HOLD};
      S_HOLD:  w = '{OP_HOLD,  WT_NONE, BR_ALWAYS,   S_CMPRD, S_CMPRD};
      S_CMPRD: w = '{OP_CMPRD, WT_NONE, BR_J_LT_GAP, S_PLACE, S_CMP};
      S_CMP:   w = '{OP_CMP,   WT_NONE, BR_LESS,     S_CMPRD, S_PLACE};
      S_PLACE: w = '{OP_PLACE, WT_NONE, BR_MORE_I,   S_ILOAD, S_HALVE};
      S_HALVE: w = '{OP_HALVE, WT_NONE, BR_HALF_NZ,  S_PASS,  S_ERD};
      S_ERD:   w = '{OP_ERD,   WT_NONE, BR_ALWAYS,   S_EOUT,  S_EOUT};
      S_EOUT:  w = '{OP_EOUT,  WT_OUT,  BR_LAST_K,   S_IDLE,  S_ERD};
      default: w = '{OP_LOAD,  WT_IN,   BR_ALWAYS,   S_IDLE,  S_IDLE};
    endcase
    return w;
  endfunction

  logic [STEP_W-1:0] pc;
  logic [STEP_W-1:0] pc_next;
  ctrl_word_t        cw;
  logic              go;
  logic              taken;

  assign cw = rom(pc);

  always_comb begin
    unique case (cw.wait_on)
      WT_IN:   go = flags.in_valid;
      WT_OUT:  go = flags.out_free;
      default: go = 1'b1;
    endcase
  end

  always_comb begin
    unique case (cw.br)
      BR_NOTLAST:  taken = !flags.is_last;
      BR_SETUP_G0: taken = flags.setup_gap0;
      BR_HALF_NZ:  taken = flags.half_nz;
      BR_J_LT_GAP: taken = flags.j_lt_gap;
      BR_LESS:     taken = flags.less;
      BR_MORE_I:   taken = flags.more_i;
      BR_LAST_K:   taken = flags.last_k;
      default:     taken = 1'b1;
    endcase
  end

  assign pc_next = go ? (taken ? cw.tgt_true : cw.tgt_false) : pc;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  assign ctl.op = cw.op;
  assign ctl.go = go;

endmodule

/* design/ssoc_datapath.sv */
// sort datapath: index and gap registers, held element, tally, output register
module ssoc_datapath #(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ssoc_pkg::ssoc_ctl_t   ctl,
  output ssoc_pkg::ssoc_flags_t flags,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ssoc_pkg::in_word_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ssoc_pkg::out_word_t   out_data
);
  import ssoc_pkg::*;

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CW-1:0] MAX_FILL = CW'(MAX_ELEMENTS);

  logic [CW-1:0]      fill;
  logic [CW-1:0]      gap;
  logic [CW-1:0]      i;
  logic [CW-1:0]      j;
  logic [CW-1:0]      k;
  logic [DATA_W-1:0]  held;
  logic [COUNT_W-1:0] tally;
  logic [COUNT_W-1:0] tally_inc;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;

  logic          fire;
  logic          has_room;
  logic          less;
  logic          more_i;
  logic          last_k;
  logic [CW-1:0] j_gap;
  logic [CW:0]   i_plus;
  logic [CW:0]   k_plus;

  assign fire      = ctl.go;
  assign in_ready  = (ctl.op == OP_LOAD);
  assign has_room  = (fill < MAX_FILL);
  assign tally_inc = (tally == {COUNT_W{1'b1}}) ? tally : tally + COUNT_W'(1);
  assign less      = $signed(held) < $signed(rd_data);
  assign j_gap     = j - gap;
  assign i_plus    = {1'b0, i} + (CW+1)'(1);
  assign k_plus    = {1'b0, k} + (CW+1)'(1);
  assign more_i    = (i_plus < {1'b0, fill});
  assign last_k    = (k_plus == {1'b0, fill});

  assign flags.in_valid   = in_valid;
  assign flags.out_free   = !out_valid || out_ready;
  assign flags.is_last    = in_data.is_last;
  assign flags.setup_gap0 = ((fill >> 1) == '0);
  assign flags.half_nz    = ((gap >> 1) != '0);
  assign flags.j_lt_gap   = (j < gap);
  assign flags.less       = less;
  assign flags.more_i     = more_i;
  assign flags.last_k     = last_k;

  // store port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = j[AW-1:0];
    wr_data = held;
    rd_en   = 1'b0;
    rd_addr = i[AW-1:0];
    case (ctl.op)
      OP_LOAD: begin
        wr_en   = fire && has_room;
        wr_addr = fill[AW-1:0];
        wr_data = in_data.value;
      end
      OP_ILOAD: begin
        rd_en = 1'b1;
      end
      OP_CMPRD: begin
        rd_en   = 1'b1;
        rd_addr = j_gap[AW-1:0];
      end
      OP_CMP: begin
        wr_en   = less;
        wr_data = rd_data;
      end
      OP_PLACE: begin
        wr_en = 1'b1;
      end
      OP_ERD: begin
        rd_en   = 1'b1;
        rd_addr = k[AW-1:0];
      end
      default: ;
    endcase
  end

  ssoc_store #(
    .DEPTH (MAX_ELEMENTS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      tally     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready && !(fire && ctl.op == OP_EOUT)) begin
        out_valid <= 1'b0;
      end
      if (fire) begin
        unique case (ctl.op)
          OP_LOAD: begin
            if (has_room) begin
              fill <= fill + CW'(1);
            end
          end
          OP_SETUP: tally <= '0;
          OP_CMP:   tally <= tally_inc;
          OP_PLACE: tally <= tally_inc;
          OP_EOUT: begin
            out_valid <= 1'b1;
            if (last_k) begin
              fill <= '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (fire) begin
      case (ctl.op)
        OP_SETUP: begin
          gap <= fill >> 1;
          k   <= '0;
        end
        OP_PASS:  i <= gap;
        OP_ILOAD: j <= i;
        OP_HOLD:  held <= rd_data;
        OP_CMP: begin
          if (less) begin
            j <= j_gap;
          end
        end
        OP_PLACE: i <= i_plus[CW-1:0];
        OP_HALVE: gap <= gap >> 1;
        OP_EOUT: begin
          out_data.sorted_value <= rd_data;
          out_data.end_of_set   <= last_k;
          out_data.op_count     <= tally;
          k                     <= k_plus[CW-1:0];
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= MAX_FILL)
    else $error("fill count beyond store depth");

  a_cmp_in_range: assert property (@(posedge clk) disable iff (rst)
    (fire && ctl.op == OP_CMP) |-> (j >= gap))
    else $error("comparison issued with j below gap");

  a_set_done_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && ctl.op == OP_EOUT && last_k) |=> (fill == '0))
    else $error("fill count not cleared after last word");

  a_tally_monotone: assert property (@(posedge clk) disable iff (rst)
    (ctl.op != OP_SETUP) |=> (tally >= $past(tally)))
    else $error("operation tally decreased outside setup");
`endif

endmodule

/* design/shell_sort_with_op_count.sv */
// top level of the shell sort block with operation count
//
// input channel (in_valid / in_ready / in_data): one word per element, signed
// 32-bit value plus is_last; the word with is_last set closes the set and
// starts the sort. words beyond MAX_ELEMENTS are dropped, but a dropped last
// word still starts the sort of what is held.
// output channel (out_valid / out_ready / out_data): one word per sorted
// element in ascending order, end_of_set on the final one, each carrying the
// saturating count of comparisons plus placements for the set.
// steps: loading takes the load step per word. the sort runs a setup step, a
// pass and a halve step per gap pass, load, hold and place steps per insertion
// (plus one more compare-read when it runs to the front of its chain) and a
// compare-read and a compare step per comparison, all set by the single read
// port of the element store driven by the microcode sequencer. each result is
// a read step, then an emit step that loads the output register.
// a stalled receiver holds the output register and the sequencer waits in
// its emit step; in_ready is high only while the sequencer sits in its load
// step, which it may reach while the final result still waits to be taken.
// reset (rst, synchronous) empties the set, clears the tally and drops any
// pending output word; store contents are not cleared.
module shell_sort_with_op_count #(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ssoc_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ssoc_pkg::out_word_t out_data
);
  import ssoc_pkg::*;

  ssoc_ctl_t   ctl;    // current step's operation and whether it fires
  ssoc_flags_t flags;  // branch and wait conditions back to the sequencer

  // program counter and rom of control words
  ssoc_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctl   (ctl)
  );

  // registers, store and output word register
  ssoc_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .flags     (flags),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* bench/testbench.sv */
// self-checking testbench for the shell sort block with operation count
`timescale 1ns / 1ps

module testbench;
  import ssoc_pkg::*;

  localparam int CAPACITY = 64;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam int RANDOM_ITEMS = 350;
  localparam int LONG_HOLD = 400;
  localparam int CYCLE_LIMIT = 400_000;

  // how a directed row gets its expected words
  typedef enum bit {BY_MODEL, TYPED_IN} check_e;

  typedef struct packed {
    logic signed [DATA_W-1:0]  value;
    logic                      is_last;
    check_e                    check;
    logic signed [DATA_W-1:0]  exp_value;
    logic        [COUNT_W-1:0] exp_count;
  } row_t;

  localparam int NUM_ROWS = 24;
  localparam row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // one-element sets come back as they are, with nothing counted
    '{32'h8000_0000, 1'b1, TYPED_IN, 32'h8000_0000, 16'd0},
    '{32'h7fff_ffff, 1'b1, TYPED_IN, 32'h7fff_ffff, 16'd0},
    '{32'h0000_0000, 1'b1, TYPED_IN, 32'h0000_0000, 16'd0},
    '{32'hffff_ffff, 1'b1, TYPED_IN, 32'hffff_ffff, 16'd0},
    // two extremes in reverse order
    '{32'h7fff_ffff, 1'b0, BY_MODEL, 32'd0, 16'd0},
    '{32'h8000_0000, 1'b1, BY_MODEL, 32'd0, 16'd0},
    // all equal, nothing may move
    '{32'd5, 1'b0, BY_MODEL, 32'd0, 16'd0},
    '{32'd5, 1'b0, BY_MODEL, 32'd0, 16'd0},
    '{32'd5, 1'b1, BY_MODEL, 32'd0, 16'd0},
    // strictly descending across the sign boundary
    '{32'h7fff_ffff, 1'b0, BY_MODEL, 32'd0, 16'd0},
    '{32'd1000, 1'b0, BY_MODEL, 32'd0, 16'd0},
    '{32'd0, 1'b0, BY_MODEL, 32'd0, 16'd0},
    '{32'hffff_ffff, 1'b0, BY_MODEL, 32'd0, 16'd0},
    '{32'hffff_fc18, 1'b0, BY_MODEL, 32'd0, 16'd0},
    '{32'h8000_0000, 1'b1, BY_MODEL, 32'd0, 16'd0},
    // already ascending
    '{32'd1, 1'b0, BY_MODEL, 32'd0, 16'd0},
    '{32'd2, 1'b0, BY_MODEL, 32'd0, 16'd0},
    '{32'd3, 1'b0, BY_MODEL, 32'd0, 16'd0},
    '{32'd4, 1'b1, BY_MODEL, 32'd0, 16'd0},
    // duplicates mixed with signs
    '{32'd3, 1'b0, BY_MODEL, 32'd0, 16'd0},
    '{32'hffff_fffd, 1'b0, BY_MODEL, 32'd0, 16'd0},
    '{32'd3, 1'b0, BY_MODEL, 32'd0, 16'd0},
    '{32'd0, 1'b0, BY_MODEL, 32'd0, 16'd0},
    '{32'hffff_fffd, 1'b1, BY_MODEL, 32'd0, 16'd0}
  };

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  shell_sort_with_op_count #(.MAX_ELEMENTS(CAPACITY)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state: the set being collected and its running tally
  logic signed [DATA_W-1:0] element_mem [CAPACITY];
  int                       held_count = 0;
  logic [COUNT_W-1:0]       op_tally = '0;

  out_word_t sorted_words [$];   // words produced by the last accepted element
  out_word_t pending_words [$];  // expected words not yet seen on the output
  int        error_count = 0;
  int        cycle_count = 0;
  bit        hold_request = 1'b0;
  bit        hold_done = 1'b0;

  function automatic void bump_tally();
    if (op_tally != COUNT_MAX) op_tally++;
  endfunction

  // store one element; a last word sorts the held set and emits it
  function automatic void take_element(in_word_t w);
    int gap, i, j;
    logic signed [DATA_W-1:0] held;
    out_word_t r;
    sorted_words.delete();
    // a full store drops the word, but its last mark still counts
    if (held_count < CAPACITY) begin
      element_mem[held_count] = w.value;
      held_count++;
    end
    if (!w.is_last) return;
    op_tally = '0;
    for (gap = held_count / 2; gap > 0; gap = gap / 2) begin
      for (i = gap; i < held_count; i++) begin
        held = element_mem[i];
        j = i;
        // gapped insertion, only strictly greater elements shift
        while (j >= gap) begin
          bump_tally();
          if (held < element_mem[j - gap]) begin
            element_mem[j] = element_mem[j - gap];
            j -= gap;
          end else begin
            break;
          end
        end
        element_mem[j] = held;
        bump_tally();
      end
    end
    for (i = 0; i < held_count; i++) begin
      r.sorted_value = element_mem[i];
      r.end_of_set = (i == held_count - 1);
      r.op_count = op_tally;
      sorted_words.push_back(r);
    end
    held_count = 0;
    op_tally = '0;
  endfunction

  // drive a word at the falling edge and hold it until the block takes it
  task automatic offer_word(in_word_t w, check_e check, out_word_t typed);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    take_element(w);
    if (check == TYPED_IN) begin
      // one-element set, the expected word is written in the row
      if (sorted_words.size() != 1) begin
        $error("row expects one word, predictor made %0d", sorted_words.size());
        error_count++;
      end
      pending_words.push_back(typed);
    end else begin
      foreach (sorted_words[k]) pending_words.push_back(sorted_words[k]);
    end
  endtask

  task automatic pause_sender(int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  task automatic wait_for_drain();
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // receiver: one long hold-off on request, otherwise a rotating stall pattern
  initial begin : receiver
    int rx_cycle;
    int mode;
    rx_cycle = 0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (hold_request && !hold_done) begin
        // block fills up and must stall its input meanwhile
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        mode = (rx_cycle / 97) % 4;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (rx_cycle % 3 == 0);
        endcase
      end
    end
  end

  // output check against the oldest expected word
  always @(posedge clk) begin : output_check
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: sorted_value %0d end_of_set %0b op_count %0d",
               out_data.sorted_value, out_data.end_of_set, out_data.op_count);
        error_count++;
      end else begin
        want = pending_words.pop_front();
        if (out_data.sorted_value !== want.sorted_value) begin
          $error("sorted_value: expected %0d, got %0d",
                 want.sorted_value, out_data.sorted_value);
          error_count++;
        end
        if (out_data.end_of_set !== want.end_of_set) begin
          $error("end_of_set: expected %0b, got %0b",
                 want.end_of_set, out_data.end_of_set);
          error_count++;
        end
        if (out_data.op_count !== want.op_count) begin
          $error("op_count: expected %0d, got %0d", want.op_count, out_data.op_count);
          error_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    in_word_t  w;
    out_word_t typed;
    int        sent;
    int        set_no;
    int        set_size;
    int        burst_left;
    bit        narrow;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed rows
    foreach (DIRECTED_ROWS[r]) begin
      w.value = DIRECTED_ROWS[r].value;
      w.is_last = DIRECTED_ROWS[r].is_last;
      typed.sorted_value = DIRECTED_ROWS[r].exp_value;
      typed.end_of_set = 1'b1;
      typed.op_count = DIRECTED_ROWS[r].exp_count;
      offer_word(w, DIRECTED_ROWS[r].check, typed);
    end
    typed = '0;

    // random sets, mostly small, with a full store and an overflowing one
    sent = 0;
    set_no = 0;
    burst_left = 0;
    while (sent < RANDOM_ITEMS) begin
      if (set_no == 2) set_size = CAPACITY + 2;
      else if (set_no == 6) set_size = CAPACITY;
      else if ($urandom_range(0, 9) == 0) set_size = 1;
      else set_size = $urandom_range(2, 12);
      narrow = ($urandom_range(0, 3) == 0);

      if (set_no == 4) hold_request = 1'b1;
      if (set_no == 9 || set_no % 15 == 14) begin
        // quiet input until every expected word has come out
        pause_sender(1);
        wait_for_drain();
      end

      for (int e = 0; e < set_size; e++) begin
        if (burst_left == 0) begin
          pause_sender(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
          burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        // narrow sets repeat values so equal keys show up often
        if (narrow) w.value = $signed($urandom_range(0, 8)) - 4;
        else w.value = $urandom;
        w.is_last = (e == set_size - 1);
        offer_word(w, BY_MODEL, typed);
        sent++;
      end
      set_no++;
    end

    pause_sender(1);
    wait_for_drain();
    repeat (16) @(posedge clk);
    if (error_count == 0 && pending_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
